// ----- rtl/core/sobel_edge_magnitude_assert.svh -----
// assertion macros for the sobel edge magnitude block
// no dependencies; used by the top level only
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`ifndef SYNTH
`define SEM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SEM_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SEM_ASSERT(label, clk, rst_n, prop, msg)
`define SEM_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/core/sem_pkg.sv -----
// shared types and constants for the sobel edge magnitude block
// no dependencies
package sem_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam logic [10:0] WIDTH_RESET = 11'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;
    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
    localparam int QUEUE_DEPTH = 16;

    // one window job handed from front to back
    typedef struct packed {
        logic [71:0] top;
        logic [71:0] mid;
        logic [71:0] bot;
        logic has_l;
        logic has_r;
        logic has_t;
        logic has_b;
        logic last;
    } job_t;

    // per channel result beat
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic last;
    } res_t;
endpackage

// ----- rtl/core/sem_front.sv -----
// front: line stores, window, counters; emits window jobs, holding off a new beat while busy
// depends on sem_pkg
module sem_front #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic take,
    input  logic kind,
    input  logic [23:0] pix_in,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] w,
    input  logic [11:0] h,
    output logic busy,
    output logic job_valid,
    output sem_pkg::job_t job
);
    localparam int CW = $clog2(MAX_WIDTH+1);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [23:0] upper_mem [MAX_WIDTH];
    logic [23:0] middle_mem [MAX_WIDTH];
    logic [23:0] win_reg [9];
    logic [23:0] up_reg, mid_reg, pix_reg;
    logic kind_reg, busy_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [12:0] in_row_reg;
    logic [11:0] out_row_reg;
    logic [CW-1:0] ic, oc, ic1, oc1;
    logic [12:0] ir, ir1;
    logic [11:0] orw, orw1;
    logic [23:0] pix;
    logic primed, last;

    // wrap counters that a width change left out of range
    always_comb
    begin
        ic = in_col_reg; ir = in_row_reg;
        if (ic >= w) begin ic = '0; ir = ir + 13'd1; end
        oc = out_col_reg; orw = out_row_reg;
        if (oc >= w) begin oc = '0; orw = orw + 12'd1; end
        pix = (kind_reg || ir >= {1'b0, h}) ? 24'd0 : pix_reg;
        primed = ir >= 13'd2 || (ir == 13'd1 && ic != '0);
        ic1 = ic + 1'b1; ir1 = ir;
        if (ic1 >= w) begin ic1 = '0; ir1 = ir + 13'd1; end
        last = ({1'b0, orw} + 13'd1 >= {1'b0, h}) && (oc + 1'b1 >= w);
        oc1 = oc + 1'b1; orw1 = orw;
        if (oc1 >= w) begin oc1 = '0; orw1 = orw + 12'd1; end
    end

    // line stores: registered read on accept, write back in the busy cycle
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            up_reg <= upper_mem[ic[AW-1:0]];
            mid_reg <= middle_mem[ic[AW-1:0]];
            kind_reg <= kind;
            pix_reg <= pix_in;
        end
        if (busy_reg)
        begin
            upper_mem[ic[AW-1:0]] <= mid_reg;
            middle_mem[ic[AW-1:0]] <= pix;
        end
    end

    // window, counters and job register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
            in_col_reg <= '0; in_row_reg <= '0;
            out_col_reg <= '0; out_row_reg <= '0;
            busy_reg <= 1'b0;
            job_valid <= 1'b0;
            job <= '0;
        end
        else
        begin
            busy_reg <= take;
            job_valid <= busy_reg && primed;
            if (busy_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3] <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= up_reg; win_reg[5] <= mid_reg; win_reg[8] <= pix;
                job.top <= {win_reg[1], win_reg[2], up_reg};
                job.mid <= {win_reg[4], win_reg[5], mid_reg};
                job.bot <= {win_reg[7], win_reg[8], pix};
                job.has_l <= oc != '0;
                job.has_r <= oc + 1'b1 < w;
                job.has_t <= orw != '0;
                job.has_b <= {1'b0, orw} + 13'd1 < {1'b0, h};
                job.last <= last;
                in_col_reg <= ic1; in_row_reg <= ir1;
                if (!primed)
                begin
                    out_col_reg <= oc; out_row_reg <= orw;
                end
                else if (last)
                begin
                    in_col_reg <= '0; in_row_reg <= '0;
                    out_col_reg <= '0; out_row_reg <= '0;
                end
                else
                begin
                    out_col_reg <= oc1; out_row_reg <= orw1;
                end
            end
        end
    end

    assign busy = busy_reg;
endmodule

// ----- rtl/core/sem_back.sv -----
// back: gradients, squares, rounded root per channel, pipelined
// depends on sem_pkg
module sem_back (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sem_pkg::job_t job,
    output logic out_valid,
    output sem_pkg::res_t res
);
    localparam int ST = 10;
    logic [ST-1:0] v_reg;
    logic [20:0] s_reg [3];
    logic [7:0] r_reg [ST-1][3];
    logic [20:0] sp_reg [ST-2][3];
    logic last_reg [ST];

    function automatic logic [8:0] tap(input logic [71:0] row, input int k, input int c,
                                       input logic keep);
        return keep ? {1'b0, row[(2-k)*24 + (2-c)*8 +: 8]} : 9'd0;
    endfunction

    // gradients and sum of squares, one register stage
    always_ff @(posedge clk)
    begin
        logic signed [11:0] gx, gy;
        logic [10:0] ax, ay;
        for (int c = 0; c < 3; c++)
        begin
            gx = $signed({3'b0, tap(job.top, 2, c, job.has_t && job.has_r)})
               + 12'sd2 * $signed({3'b0, tap(job.mid, 2, c, job.has_r)})
               + $signed({3'b0, tap(job.bot, 2, c, job.has_b && job.has_r)})
               - $signed({3'b0, tap(job.top, 0, c, job.has_t && job.has_l)})
               - 12'sd2 * $signed({3'b0, tap(job.mid, 0, c, job.has_l)})
               - $signed({3'b0, tap(job.bot, 0, c, job.has_b && job.has_l)});
            gy = $signed({3'b0, tap(job.bot, 0, c, job.has_b && job.has_l)})
               + 12'sd2 * $signed({3'b0, tap(job.bot, 1, c, job.has_b)})
               + $signed({3'b0, tap(job.bot, 2, c, job.has_b && job.has_r)})
               - $signed({3'b0, tap(job.top, 0, c, job.has_t && job.has_l)})
               - 12'sd2 * $signed({3'b0, tap(job.top, 1, c, job.has_t)})
               - $signed({3'b0, tap(job.top, 2, c, job.has_t && job.has_r)});
            ax = gx[11] ? 11'(-gx) : gx[10:0];
            ay = gy[11] ? 11'(-gy) : gy[10:0];
            s_reg[c] <= 21'(ax) * 21'(ax) + 21'(ay) * 21'(ay);
        end
        last_reg[0] <= job.last;
    end

    // root digits, one bit per stage, then rounding
    always_ff @(posedge clk)
    begin
        logic [7:0] t;
        for (int c = 0; c < 3; c++)
        begin
            t = 8'h80;
            r_reg[0][c] <= (21'(t) * 21'(t) <= s_reg[c]) ? t : 8'd0;
            sp_reg[0][c] <= s_reg[c];
            for (int k = 1; k < 8; k++)
            begin
                t = r_reg[k-1][c] | (8'h80 >> k);
                r_reg[k][c] <= (21'(t) * 21'(t) <= sp_reg[k-1][c]) ? t : r_reg[k-1][c];
                sp_reg[k][c] <= sp_reg[k-1][c];
            end
            if (sp_reg[7][c] >= 21'd65281) r_reg[8][c] <= 8'd255;
            else if (sp_reg[7][c] > 21'(r_reg[7][c]) * 21'(r_reg[7][c]) + 21'(r_reg[7][c]))
                r_reg[8][c] <= r_reg[7][c] + 8'd1;
            else r_reg[8][c] <= r_reg[7][c];
        end
        for (int k = 1; k < ST; k++) last_reg[k] <= last_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else v_reg <= {v_reg[ST-2:0], in_valid};
    end

    assign out_valid = v_reg[ST-1];
    assign res = '{red: r_reg[8][0], green: r_reg[8][1], blue: r_reg[8][2],
                   last: last_reg[ST-1]};
endmodule

// ----- rtl/core/sem_queue.sv -----
// result queue between back end and output ports
// depends on sem_pkg
module sem_queue #(
    parameter int DEPTH = sem_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  sem_pkg::res_t wdata,
    input  logic rd,
    output sem_pkg::res_t rdata,
    output logic empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = $clog2(DEPTH);
    sem_pkg::res_t mem_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= PW'((wp_reg + 1'b1) % DEPTH);
            if (rd) rp_reg <= PW'((rp_reg + 1'b1) % DEPTH);
            cnt_reg <= cnt_reg + wr - rd;
        end
    end

    assign rdata = mem_reg[rp_reg];
    assign empty = cnt_reg == '0;
    assign count = cnt_reg;
endmodule

// ----- rtl/core/sobel_edge_magnitude.sv -----
// top level of the sobel edge magnitude block
// depends on sem_pkg, sem_front, sem_back, sem_queue, assert header
//
// channel   handshake        payload
// input     push / full      kind, red_in, green_in, blue_in
// result    pop / empty      red_out, green_out, blue_out, frame_last
// config    cfg_valid/ready  cfg_index, cfg_data
//
// a new item is held off while busy: the accept edge reads the line stores, then the busy
// edge shifts the window and registers the job for the back
// a result reaches the ports through the job register, the 10 back stages
// and the queue write
// full is high the cycle after each accept and while jobs plus queued beats
// could overrun the 16-entry queue; reset does not clear the line stores
`include "sobel_edge_magnitude_assert.svh"
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic kind,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic empty,
    input  logic pop,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic frame_last,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_index,
    input  logic [11:0] cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH+1);
    localparam int QD = sem_pkg::QUEUE_DEPTH;
    localparam int INFL = 11;

    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic [CW-1:0] w;
    logic [11:0] h;
    logic take, busy, job_valid, res_valid, rd;
    sem_pkg::job_t job;
    sem_pkg::res_t res, head;
    logic [$clog2(QD+1)-1:0] qcount;
    logic [4:0] fly_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sem_pkg::CFG_WIDTH:  width_reg <= cfg_data[10:0];
                sem_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb
    begin
        if (width_reg == 11'd0) w = CW'(1);
        else if (32'(width_reg) > MAX_WIDTH) w = CW'(MAX_WIDTH);
        else w = CW'(width_reg);
        h = (height_reg == 12'd0) ? 12'd1 : height_reg;
    end

    // credit: jobs in the back plus queued beats must fit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fly_reg <= '0;
        else fly_reg <= fly_reg + 5'(job_valid) - 5'(res_valid);
    end
    assign full = busy || ((32'(fly_reg) + 32'(qcount)) >= QD - 1);
    assign take = push && !full;
    assign rd = pop && !empty;

    sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk, .rst_n, .take, .kind,
        .pix_in({red_in, green_in, blue_in}),
        .w, .h, .busy, .job_valid, .job
    );

    sem_back u_back (
        .clk, .rst_n, .in_valid(job_valid), .job,
        .out_valid(res_valid), .res
    );

    sem_queue #(.DEPTH(QD)) u_queue (
        .clk, .rst_n, .wr(res_valid), .wdata(res), .rd,
        .rdata(head), .empty, .count(qcount)
    );

    assign red_out = head.red;
    assign green_out = head.green;
    assign blue_out = head.blue;
    assign frame_last = head.last;

    `SEM_NEVER(a_no_overflow, clk, rst_n, res_valid && qcount == QD && !rd, "queue overrun")
    `SEM_NEVER(a_fly_bound, clk, rst_n, 32'(fly_reg) > INFL + 2, "too many beats in flight")
    `SEM_ASSERT(a_full_held, clk, rst_n, (32'(fly_reg) + 32'(qcount) >= QD) |-> full, "full low")
endmodule
